/* rtl/aabb_pkg.sv */
// shared types, constants and codes of the blocked move block
`timescale 1ns / 1ps

package aabb_pkg;

  // table geometry
  localparam int MaxRects = 64;
  localparam int IdxW     = $clog2(MaxRects);
  localparam int CntW     = 7;

  // field widths
  localparam int CoordW   = 16;
  localparam int SizeW    = 12;
  localparam int OffW     = 11;
  localparam int ActW     = 2;
  localparam int SlotW    = 6;
  localparam int SumW     = CoordW + 2;

  // action codes
  localparam logic [ActW-1:0] ActLoad = 2'd0;
  localparam logic [ActW-1:0] ActMove = 2'd1;
  localparam logic [ActW-1:0] ActTest = 2'd2;

  // one rectangle: top-left origin and size
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic        [SizeW-1:0]  w;
    logic        [SizeW-1:0]  h;
  } rect_t;

  localparam int RectW = $bits(rect_t);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_PASS = 2'b10
  } state_e;

  // which test the current pass makes
  typedef enum logic [2:0] {
    PH_X = 3'b001,
    PH_Y = 3'b010,
    PH_F = 3'b100
  } phase_e;

endpackage

/* rtl/aabb_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module aabb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/aabb_ovl.sv */
// strict overlap compare of a box against one table rectangle
`timescale 1ns / 1ps

module aabb_ovl (
  input  aabb_pkg::rect_t box_i,
  input  aabb_pkg::rect_t rect_i,
  output logic            hit_o
);

  import aabb_pkg::*;

  logic signed [SumW-1:0] bx, by, rx, ry;
  logic signed [SumW-1:0] bx_end, by_end, rx_end, ry_end;

  assign bx     = SumW'(box_i.x);
  assign by     = SumW'(box_i.y);
  assign rx     = SumW'(rect_i.x);
  assign ry     = SumW'(rect_i.y);
  assign bx_end = bx + $signed(SumW'(box_i.w));
  assign by_end = by + $signed(SumW'(box_i.h));
  assign rx_end = rx + $signed(SumW'(rect_i.w));
  assign ry_end = ry + $signed(SumW'(rect_i.h));

  // edges that only touch give no hit; a zero size side still hits strictly inside the other
  assign hit_o = (bx < rx_end) && (rx < bx_end) && (by < ry_end) && (ry < by_end);

endmodule

/* rtl/aabb_step.sv */
// saturating add of a step to a coordinate
`timescale 1ns / 1ps

module aabb_step (
  input  logic signed [aabb_pkg::CoordW-1:0] base_i,
  input  logic signed [aabb_pkg::OffW-1:0]   step_i,
  output logic signed [aabb_pkg::CoordW-1:0] sum_o
);

  import aabb_pkg::*;

  logic signed [CoordW:0] sum;

  assign sum = (CoordW+1)'(base_i) + (CoordW+1)'(step_i);

  always_comb begin
    if (sum[CoordW] == sum[CoordW-1]) begin
      sum_o = sum[CoordW-1:0];
    end else if (sum[CoordW]) begin
      sum_o = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      sum_o = {1'b0, {(CoordW-1){1'b1}}};
    end
  end

endmodule

/* rtl/aabb_blocked_move.sv */
// top level: obstacle table, pass sequencer and result register
//
//  channel | signals                            | direction | accepted when
//  --------+------------------------------------+-----------+---------------------
//  cfg     | cfg_valid_i cfg_ready_o cfg_data_i | in        | valid and ready
//  in      | in_valid_i in_stall_o + fields     | in        | valid and not stall
//  out     | out_valid_o out_stall_i + fields   | out       | valid and not stall
//
// a load word goes into the table at the edge it is accepted
// a pass reads entries 0 .. n-1 (n = clamped rect_count)
// a move makes two passes, a third when both steps were undone
// a test makes one pass; every pass reads the table through the single ram read port
// reset clears the control state and rect_count; table contents are kept as is
// a finished result waits in the output register, a later one holds in the sequencer
`timescale 1ns / 1ps

module aabb_blocked_move (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [aabb_pkg::CntW-1:0]           cfg_data_i,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [aabb_pkg::ActW-1:0]           action_i,
  input  logic [aabb_pkg::SlotW-1:0]          entry_index_i,
  input  logic signed [aabb_pkg::CoordW-1:0]  pos_x_i,
  input  logic signed [aabb_pkg::CoordW-1:0]  pos_y_i,
  input  logic [aabb_pkg::SizeW-1:0]          box_width_i,
  input  logic [aabb_pkg::SizeW-1:0]          box_height_i,
  input  logic signed [aabb_pkg::OffW-1:0]    offset_x_i,
  input  logic signed [aabb_pkg::OffW-1:0]    offset_y_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [aabb_pkg::CoordW-1:0]  new_x_o,
  output logic signed [aabb_pkg::CoordW-1:0]  new_y_o,
  output logic                                blocked_x_o,
  output logic                                blocked_y_o,
  output logic                                overlap_o
);

  import aabb_pkg::*;

  // control state
  state_e               state_q, state_d;
  phase_e               phase_q, phase_d;
  logic [CntW-1:0]      cnt_q, cnt_d;     // clamped rect_count
  logic [CntW-1:0]      idx_q, idx_d;     // next entry to read
  logic                 pend_q, pend_d;   // ram data valid this cycle
  logic                 hit_q, hit_d;     // running or of the pass
  logic                 out_valid_q, out_valid_d;

  // payload of the word at work
  logic signed [CoordW-1:0] px_q, px_d;
  logic signed [CoordW-1:0] py_q, py_d;
  logic [SizeW-1:0]         w_q, w_d;
  logic [SizeW-1:0]         h_q, h_d;
  logic signed [OffW-1:0]   oy_q, oy_d;
  logic signed [CoordW-1:0] cur_x_q, cur_x_d;
  logic signed [CoordW-1:0] cur_y_q, cur_y_d;
  logic                     bx_q, bx_d;
  logic                     by_q, by_d;

  // result register
  logic signed [CoordW-1:0] new_x_q, new_x_d;
  logic signed [CoordW-1:0] new_y_q, new_y_d;
  logic                     blk_x_q, blk_x_d;
  logic                     blk_y_q, blk_y_d;
  logic                     ovl_q, ovl_d;

  logic                 in_acc;
  logic                 out_free;
  logic                 ram_we;
  logic [RectW-1:0]     ram_wdata;
  logic [RectW-1:0]     ram_rdata;
  rect_t                box;
  rect_t                rect_rd;
  logic                 ovl_hit;
  logic signed [CoordW-1:0] step_base;
  logic signed [OffW-1:0]   step_off;
  logic signed [CoordW-1:0] step_sum;
  logic                 pass_done;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // loads go straight into the table; slots past the table are dropped
  assign ram_we    = in_acc && (action_i == ActLoad) && (int'(entry_index_i) < MaxRects);
  assign ram_wdata = {pos_x_i, pos_y_i, box_width_i, box_height_i};

  aabb_ram #(
    .Width (RectW),
    .Depth (MaxRects)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IdxW'(entry_index_i)),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  // shared compare unit, one table entry per cycle
  assign box     = '{x: cur_x_q, y: cur_y_q, w: w_q, h: h_q};
  assign rect_rd = rect_t'(ram_rdata);

  aabb_ovl u_ovl (
    .box_i  (box),
    .rect_i (rect_rd),
    .hit_o  (ovl_hit)
  );

  // shared step adder: x step at accept, y step after the x pass
  assign step_base = (state_q == ST_IDLE) ? pos_x_i : py_q;
  assign step_off  = (state_q == ST_IDLE) ? offset_x_i : oy_q;

  aabb_step u_step (
    .base_i (step_base),
    .step_i (step_off),
    .sum_o  (step_sum)
  );

  // all entries read and the last one compared
  assign pass_done = (idx_q >= cnt_q) && !pend_q;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    pend_d      = 1'b0;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    px_d        = px_q;
    py_d        = py_q;
    w_d         = w_q;
    h_d         = h_q;
    oy_d        = oy_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    bx_d        = bx_q;
    by_d        = by_q;
    new_x_d     = new_x_q;
    new_y_d     = new_y_q;
    blk_x_d     = blk_x_q;
    blk_y_d     = blk_y_q;
    ovl_d       = ovl_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i && cfg_ready_o) begin
      cnt_d = (int'(cfg_data_i) > MaxRects) ? CntW'(MaxRects) : cfg_data_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc && (action_i == ActMove || action_i == ActTest)) begin
          px_d    = pos_x_i;
          py_d    = pos_y_i;
          w_d     = box_width_i;
          h_d     = box_height_i;
          oy_d    = offset_y_i;
          cur_y_d = pos_y_i;
          bx_d    = 1'b0;
          by_d    = 1'b0;
          idx_d   = '0;
          hit_d   = 1'b0;
          state_d = ST_PASS;
          if (action_i == ActMove) begin
            cur_x_d = step_sum;
            phase_d = PH_X;
          end else begin
            cur_x_d = pos_x_i;
            phase_d = PH_F;
          end
        end
      end
      ST_PASS: begin
        if (pend_q) begin
          hit_d = hit_q || ovl_hit;
        end
        if (idx_q < cnt_q) begin
          // issue the next read
          idx_d  = idx_q + 1'b1;
          pend_d = 1'b1;
        end else if (pass_done) begin
          case (phase_q)
            PH_X: begin
              if (hit_q) begin
                cur_x_d = px_q;
                bx_d    = 1'b1;
              end
              cur_y_d = step_sum;
              phase_d = PH_Y;
              idx_d   = '0;
              hit_d   = 1'b0;
            end
            PH_Y: begin
              if (hit_q && bx_q) begin
                // both steps undone: the start box still needs a test
                cur_y_d = py_q;
                by_d    = 1'b1;
                phase_d = PH_F;
                idx_d   = '0;
                hit_d   = 1'b0;
              end else if (out_free) begin
                // any other final box was already tested clear
                new_x_d     = cur_x_q;
                new_y_d     = hit_q ? py_q : cur_y_q;
                blk_x_d     = bx_q;
                blk_y_d     = hit_q;
                ovl_d       = 1'b0;
                out_valid_d = 1'b1;
                state_d     = ST_IDLE;
              end
            end
            PH_F: begin
              if (out_free) begin
                new_x_d     = cur_x_q;
                new_y_d     = cur_y_q;
                blk_x_d     = bx_q;
                blk_y_d     = by_q;
                ovl_d       = hit_q;
                out_valid_d = 1'b1;
                state_d     = ST_IDLE;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_X;
      cnt_q       <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    px_q    <= px_d;
    py_q    <= py_d;
    w_q     <= w_d;
    h_q     <= h_d;
    oy_q    <= oy_d;
    cur_x_q <= cur_x_d;
    cur_y_q <= cur_y_d;
    bx_q    <= bx_d;
    by_q    <= by_d;
    new_x_q <= new_x_d;
    new_y_q <= new_y_d;
    blk_x_q <= blk_x_d;
    blk_y_q <= blk_y_d;
    ovl_q   <= ovl_d;
  end

  assign out_valid_o = out_valid_q;
  assign new_x_o     = new_x_q;
  assign new_y_o     = new_y_q;
  assign blocked_x_o = blk_x_q;
  assign blocked_y_o = blk_y_q;
  assign overlap_o   = ovl_q;

endmodule

/* rtl/aabb_checker.sv */
// port level checks of the blocked move block and their bind
`timescale 1ns / 1ps

module aabb_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic [aabb_pkg::ActW-1:0]           action_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [aabb_pkg::CoordW-1:0]  new_x_o,
  input logic signed [aabb_pkg::CoordW-1:0]  new_y_o,
  input logic                                blocked_x_o,
  input logic                                blocked_y_o,
  input logic                                overlap_o
);

  import aabb_pkg::*;

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(new_x_o) && $stable(new_y_o)
      && $stable(blocked_x_o) && $stable(blocked_y_o) && $stable(overlap_o))
    else $error("stalled result word changed");

  // a move or test word keeps the block busy for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == ActMove || action_i == ActTest)
      |=> in_stall_o)
    else $error("new word taken while a pass runs");

  // loads and unused actions never block the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !(action_i == ActMove || action_i == ActTest)
      |=> !in_stall_o)
    else $error("load word stalled the input");

  // only the y step undone leaves a box that was tested clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && blocked_y_o && !blocked_x_o |-> !overlap_o)
    else $error("overlap reported at a position tested clear");

endmodule

bind aabb_blocked_move aabb_checker u_aabb_checker (.*);
